@@ rtl/core/fence_timeline_tracker_top_assert.svh @@
// Assertion macros for the fence timeline tracker.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef FENCE_TIMELINE_TRACKER_TOP_ASSERT_SVH
`define FENCE_TIMELINE_TRACKER_TOP_ASSERT_SVH

// Check a property that must hold in the same cycle as its trigger.
`define FTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a property that must hold in the cycle after its trigger.
`define FTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ftt_pkg.sv @@
package ftt_pkg;

	localparam int unsigned RING_COUNT_DEF    = 16;
	localparam int unsigned FIFO_DEPTH_DEF    = 16;
	localparam int unsigned MAX_RESULTS       = 16;
	localparam logic [15:0] STALL_LIMIT_RESET = 16'd100;
	localparam logic [15:0] STALL_MAX         = 16'hFFFF;
	// Signaled when (completed - seqno) mod 2^32 lies below this window.
	localparam logic [31:0] SIGNAL_WINDOW     = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		KIND_SUBMIT_OK = 3'd0,
		KIND_BAD_RING  = 3'd1,
		KIND_FIFO_FULL = 3'd2,
		KIND_RETIRED   = 3'd3,
		KIND_NONE      = 3'd4
	} kind_t;

	typedef enum logic {
		OP_SUBMIT = 1'b0,
		OP_POLL   = 1'b1
	} op_t;

	typedef struct packed {
		logic [31:0] seqno;
		logic [31:0] flags;
		logic [63:0] cookie;
	} fence_t;

endpackage

@@ rtl/core/ftt_fence_mem.sv @@
// Fence store: one write port, one registered read port.
module ftt_fence_mem #(
	parameter int unsigned RING_COUNT = ftt_pkg::RING_COUNT_DEF,
	parameter int unsigned FIFO_DEPTH = ftt_pkg::FIFO_DEPTH_DEF,
	localparam int unsigned RW = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1,
	localparam int unsigned FW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [RW-1:0]   wr_ring,
	input  logic [FW-1:0]   wr_slot,
	input  ftt_pkg::fence_t wr_data,
	input  logic            rd_en,
	input  logic [RW-1:0]   rd_ring,
	input  logic [FW-1:0]   rd_slot,
	output ftt_pkg::fence_t rd_data
);

	ftt_pkg::fence_t mem [RING_COUNT][FIFO_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ring][wr_slot] <= wr_data;
		end
	end

	// Hold the last read word until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_ring][rd_slot];
		end
	end

endmodule

@@ rtl/core/fence_timeline_tracker_top.sv @@
// Channel   | handshake                   | payload
// ----------+-----------------------------+------------------------------------------
// input     | in_valid / in_stall         | op ring fence_flags cookie completed_seqno
//           |                             | link_up
// result    | out_valid / out_stall       | kind out_ring out_seqno out_flags out_cookie
//           |                             | forced ring_busy last
// config    | cfg_we (no wait)            | cfg_wdata -> stall_limit
//
// For a submit, a bad ring, an idle ring or a poll that only counts a stall, the
// accept edge reads the per-ring state memory, then S_LOOK decides and loads the
// result register once the output register is free.
// A retiring poll: S_SCAN compares through the fence store read port (one fence a
// cycle) to find how many retire, then S_EMIT reads each one again and shows it,
// one result a cycle while the output is free. A forced poll skips S_SCAN.
// Reset clears the control state and one valid bit per ring; a ring without its
// valid bit reads as its reset state, so there is no clearing pass. The fence
// store itself is not cleared.
// in_stall stays high from accept until the item's last result is in the output
// register; out_stall holds that register and stalls every step that loads it.
module fence_timeline_tracker_top #(
	parameter int unsigned RING_COUNT = ftt_pkg::RING_COUNT_DEF,
	parameter int unsigned FIFO_DEPTH = ftt_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  ring,
	input  logic [31:0] fence_flags,
	input  logic [63:0] cookie,
	input  logic [31:0] completed_seqno,
	input  logic        link_up,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  out_ring,
	output logic [31:0] out_seqno,
	output logic [31:0] out_flags,
	output logic [63:0] out_cookie,
	output logic        forced,
	output logic        ring_busy,
	output logic        last,

	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	`include "fence_timeline_tracker_top_assert.svh"

	localparam int unsigned RW = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
	localparam int unsigned FW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_EMIT
	} state_t;

	// Per-ring bookkeeping, one memory word per ring.
	typedef struct packed {
		logic [31:0]   next;
		logic [31:0]   seen;
		logic [15:0]   stall;
		logic [FW-1:0] head;
		logic [CW-1:0] cnt;
	} ring_state_t;

	localparam ring_state_t ST_RESET = '{next: 32'd1, seen: '0, stall: '0, head: '0, cnt: '0};

	function automatic logic [FW-1:0] slot_of(logic [FW-1:0] head, logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(off);
		if (sum >= (CW+1)'(FIFO_DEPTH)) begin
			sum = sum - (CW+1)'(FIFO_DEPTH);
		end
		return sum[FW-1:0];
	endfunction

	state_t          state_q;
	logic [CW-1:0]   off_q;
	logic [CW-1:0]   n_q;
	logic            force_q;
	logic [15:0]     stall_limit_q;

	logic            out_valid_q;
	ftt_pkg::kind_t  kind_q;
	logic [7:0]      out_ring_q;
	logic [31:0]     out_seqno_q;
	logic [31:0]     out_flags_q;
	logic [63:0]     out_cookie_q;
	logic            forced_q;
	logic            busy_q;
	logic            last_q;

	// Latched item.
	ftt_pkg::op_t    op_q;
	logic [7:0]      ring_q;
	logic [31:0]     flags_q;
	logic [63:0]     cookie_q;
	logic [31:0]     cur_q;
	logic            link_q;

	ring_state_t     st_mem [RING_COUNT];
	logic [RING_COUNT-1:0] st_vld_q;
	ring_state_t     st_rd_q;
	logic            st_vld_rd_q;

	logic            accept;
	logic            out_free;
	logic [RW-1:0]   in_ridx;
	logic [RW-1:0]   ridx_q;
	ring_state_t     st;
	logic            bad;
	logic            full;
	logic            same_seen;
	logic [15:0]     s_inc;
	logic            hold;
	logic [CW-1:0]   cnt_cap;
	logic [31:0]     seq_dist;
	logic            signaled;
	logic [CW-1:0]   off_inc;
	logic [CW-1:0]   cnt_left;

	state_t          state_d;
	logic [CW-1:0]   off_d;
	logic [CW-1:0]   n_d;
	logic            force_d;
	logic            emit;
	ftt_pkg::kind_t  e_kind;
	logic [31:0]     e_seq;
	logic [31:0]     e_flags;
	logic [63:0]     e_cookie;
	logic            e_forced;
	logic            e_busy;
	logic            e_last;
	logic            st_we;
	ring_state_t     st_wd;
	logic            fm_we;
	logic            rd_en;
	logic [CW-1:0]   rd_off;
	ftt_pkg::fence_t fm_wd;
	ftt_pkg::fence_t fm_rd;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_ridx  = ring[RW-1:0];
	assign ridx_q   = ring_q[RW-1:0];

	// A ring never written since reset reads as its reset state.
	assign st        = st_vld_rd_q ? st_rd_q : ST_RESET;
	assign bad       = (ring_q >= 8'(RING_COUNT));
	assign full      = (st.cnt == CW'(FIFO_DEPTH));
	assign same_seen = (st.seen == cur_q);
	assign s_inc     = (st.stall == ftt_pkg::STALL_MAX) ? st.stall : st.stall + 16'd1;
	assign hold      = same_seen && ((s_inc < stall_limit_q) || link_q);
	assign cnt_cap   = (32'(st.cnt) > ftt_pkg::MAX_RESULTS) ? CW'(ftt_pkg::MAX_RESULTS) : st.cnt;
	assign seq_dist  = cur_q - fm_rd.seqno;
	assign signaled  = (seq_dist < ftt_pkg::SIGNAL_WINDOW);
	assign off_inc   = CW'(off_q + 1'b1);
	assign cnt_left  = st.cnt - n_q;

	assign fm_wd = '{seqno: st.next, flags: flags_q, cookie: cookie_q};

	always_comb begin
		state_d  = state_q;
		off_d    = off_q;
		n_d      = n_q;
		force_d  = force_q;
		emit     = 1'b0;
		e_kind   = ftt_pkg::KIND_NONE;
		e_seq    = '0;
		e_flags  = '0;
		e_cookie = '0;
		e_forced = 1'b0;
		e_busy   = 1'b0;
		e_last   = 1'b1;
		st_we    = 1'b0;
		st_wd    = st;
		fm_we    = 1'b0;
		rd_en    = 1'b0;
		rd_off   = '0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_LOOK: begin
				if (out_free) begin
					priority if (bad) begin
						emit    = 1'b1;
						e_kind  = ftt_pkg::KIND_BAD_RING;
						state_d = S_IDLE;
					end else if (op_q == ftt_pkg::OP_SUBMIT) begin
						emit    = 1'b1;
						e_busy  = 1'b1;
						state_d = S_IDLE;
						if (full) begin
							e_kind = ftt_pkg::KIND_FIFO_FULL;
						end else begin
							e_kind    = ftt_pkg::KIND_SUBMIT_OK;
							e_seq     = st.next;
							e_flags   = flags_q;
							e_cookie  = cookie_q;
							fm_we     = 1'b1;
							st_we     = 1'b1;
							st_wd.next = st.next + 32'd1;
							st_wd.cnt  = CW'(st.cnt + 1'b1);
						end
					end else if (st.cnt == '0) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end else if (hold) begin
						emit        = 1'b1;
						e_busy      = 1'b1;
						st_we       = 1'b1;
						st_wd.stall = s_inc;
						state_d     = S_IDLE;
					end else if (same_seen) begin
						// Stalled too long with the link down: retire without compare.
						force_d = 1'b1;
						n_d     = cnt_cap;
						off_d   = '0;
						rd_en   = 1'b1;
						state_d = S_EMIT;
					end else begin
						force_d = 1'b0;
						off_d   = '0;
						rd_en   = 1'b1;
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (signaled) begin
					if ((off_inc == st.cnt) || (32'(off_inc) == ftt_pkg::MAX_RESULTS)) begin
						n_d     = off_inc;
						off_d   = '0;
						rd_en   = 1'b1;
						state_d = S_EMIT;
					end else begin
						off_d  = off_inc;
						rd_en  = 1'b1;
						rd_off = off_inc;
					end
				end else if (off_q != '0) begin
					n_d     = off_q;
					off_d   = '0;
					rd_en   = 1'b1;
					state_d = S_EMIT;
				end else if (out_free) begin
					// Progress seen, but the head fence is not signaled yet.
					emit        = 1'b1;
					e_busy      = 1'b1;
					st_we       = 1'b1;
					st_wd.seen  = cur_q;
					st_wd.stall = '0;
					state_d     = S_IDLE;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					emit     = 1'b1;
					e_kind   = ftt_pkg::KIND_RETIRED;
					e_seq    = fm_rd.seqno;
					e_flags  = fm_rd.flags;
					e_cookie = fm_rd.cookie;
					e_forced = force_q;
					e_busy   = (cnt_left != '0);
					e_last   = (off_inc == n_q);
					if (e_last) begin
						st_we       = 1'b1;
						st_wd.seen  = cur_q;
						st_wd.stall = '0;
						st_wd.head  = slot_of(st.head, n_q);
						st_wd.cnt   = cnt_left;
						state_d     = S_IDLE;
					end else begin
						off_d  = off_inc;
						rd_en  = 1'b1;
						rd_off = off_inc;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	ftt_fence_mem #(
		.RING_COUNT(RING_COUNT),
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fence_mem (
		.clk    (clk),
		.wr_en  (fm_we),
		.wr_ring(ridx_q),
		.wr_slot(slot_of(st.head, st.cnt)),
		.wr_data(fm_wd),
		.rd_en  (rd_en),
		.rd_ring(ridx_q),
		.rd_slot(slot_of(st.head, rd_off)),
		.rd_data(fm_rd)
	);

	// Per-ring state memory: written at most once per item, read at accept.
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[ridx_q] <= st_wd;
		end
		if (accept) begin
			st_rd_q <= st_mem[in_ridx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q    <= '0;
			st_vld_rd_q <= 1'b0;
		end else begin
			if (st_we) begin
				st_vld_q[ridx_q] <= 1'b1;
			end
			if (accept) begin
				st_vld_rd_q <= st_vld_q[in_ridx];
			end
		end
	end

	// Capture the item.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= ftt_pkg::op_t'(op);
			ring_q   <= ring;
			flags_q  <= fence_flags;
			cookie_q <= cookie;
			cur_q    <= completed_seqno;
			link_q   <= link_up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			off_q         <= '0;
			n_q           <= '0;
			force_q       <= 1'b0;
			stall_limit_q <= ftt_pkg::STALL_LIMIT_RESET;
			out_valid_q   <= 1'b0;
			kind_q        <= ftt_pkg::KIND_NONE;
			out_ring_q    <= '0;
			out_seqno_q   <= '0;
			out_flags_q   <= '0;
			out_cookie_q  <= '0;
			forced_q      <= 1'b0;
			busy_q        <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= S_LOOK;
			end else begin
				state_q <= state_d;
			end
			off_q   <= off_d;
			n_q     <= n_d;
			force_q <= force_d;
			if (cfg_we) begin
				stall_limit_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q  <= 1'b1;
				kind_q       <= e_kind;
				out_ring_q   <= ring_q;
				out_seqno_q  <= e_seq;
				out_flags_q  <= e_flags;
				out_cookie_q <= e_cookie;
				forced_q     <= e_forced;
				busy_q       <= e_busy;
				last_q       <= e_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign out_ring   = out_ring_q;
	assign out_seqno  = out_seqno_q;
	assign out_flags  = out_flags_q;
	assign out_cookie = out_cookie_q;
	assign forced     = forced_q;
	assign ring_busy  = busy_q;
	assign last       = last_q;

	`FTT_ASSERT_NOW(a_fence_write_on_submit, fm_we, (state_q == S_LOOK) && (op_q == ftt_pkg::OP_SUBMIT) && !bad, "fence store written outside a good submit")
	`FTT_ASSERT_NOW(a_emit_in_range, state_q == S_EMIT, (n_q != '0) && (off_q < n_q) && (n_q <= st.cnt), "retire walk offset out of range")
	`FTT_ASSERT_NEXT(a_last_goes_idle, emit && e_last, (state_q == S_IDLE) && out_valid_q && last_q, "last result did not end the item")
	`FTT_ASSERT_NOW(a_count_bounded, st_we, st_wd.cnt <= CW'(FIFO_DEPTH), "ring fill count above depth")
	`FTT_ASSERT_NOW(a_forced_only_retired, out_valid_q && forced_q, kind_q == ftt_pkg::KIND_RETIRED, "forced flag on a non-retire result")

endmodule

@@ verif/fence_timeline_tracker_checker.sv @@
module fence_timeline_tracker_checker
	import ftt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [7:0]  ring,
	input  logic [31:0] fence_flags,
	input  logic [63:0] cookie,
	input  logic [31:0] completed_seqno,
	input  logic        link_up,

	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  out_ring,
	input  logic [31:0] out_seqno,
	input  logic [31:0] out_flags,
	input  logic [63:0] out_cookie,
	input  logic        forced,
	input  logic        ring_busy,
	input  logic        last,

	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,

	input  logic        wrap_up,
	output int unsigned fail_count
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RINGS = RING_COUNT_DEF;
	localparam int SLOTS = FIFO_DEPTH_DEF;

	typedef struct {
		kind_t       kind;
		logic [7:0]  rg;
		logic [31:0] seqno;
		logic [31:0] flags;
		logic [63:0] cookie;
		logic        forced;
		logic        busy;
		logic        last;
	} outcome_t;

	logic [15:0] stall_limit;
	logic [31:0] next_seq   [RINGS];
	logic [31:0] seen_seq   [RINGS];
	logic [15:0] stall_cnt  [RINGS];
	int          fifo_head  [RINGS];
	int          fifo_cnt   [RINGS];
	logic [31:0] seq_mem    [RINGS][SLOTS];
	logic [31:0] flags_mem  [RINGS][SLOTS];
	logic [63:0] cookie_mem [RINGS][SLOTS];

	outcome_t awaited_results[$];
	outcome_t want;

	function automatic outcome_t make_outcome(kind_t k, logic [7:0] rg, logic [31:0] sq,
			logic [31:0] fl, logic [63:0] ck, logic fc);
		outcome_t o;
		o.kind   = k;
		o.rg     = rg;
		o.seqno  = sq;
		o.flags  = fl;
		o.cookie = ck;
		o.forced = fc;
		o.busy   = 1'b0;
		o.last   = 1'b0;
		return o;
	endfunction

	// Advance the ring timeline by one item and queue the results it causes.
	task automatic step_timeline(input op_t o, input logic [7:0] rg, input logic [31:0] fl,
			input logic [63:0] ck, input logic [31:0] cur, input logic lk);
		outcome_t batch[$];
		int cnt;
		int hd;
		logic force_all;
		logic halt;
		logic busy;
		logic [31:0] sq;
		busy = 1'b1;
		if (rg >= RINGS) begin
			batch.push_back(make_outcome(KIND_BAD_RING, rg, '0, '0, '0, 1'b0));
			busy = 1'b0;
		end else begin
			cnt = fifo_cnt[rg];
			hd  = fifo_head[rg];
			if (o == OP_SUBMIT) begin
				if (cnt >= SLOTS) begin
					batch.push_back(make_outcome(KIND_FIFO_FULL, rg, '0, '0, '0, 1'b0));
				end else begin
					sq = next_seq[rg];
					next_seq[rg] = sq + 32'd1;
					seq_mem[rg][(hd + cnt) % SLOTS]    = sq;
					flags_mem[rg][(hd + cnt) % SLOTS]  = fl;
					cookie_mem[rg][(hd + cnt) % SLOTS] = ck;
					fifo_cnt[rg] = cnt + 1;
					batch.push_back(make_outcome(KIND_SUBMIT_OK, rg, sq, fl, ck, 1'b0));
				end
			end else if (cnt == 0) begin
				batch.push_back(make_outcome(KIND_NONE, rg, '0, '0, '0, 1'b0));
				busy = 1'b0;
			end else begin
				force_all = 1'b0;
				halt      = 1'b0;
				if (seen_seq[rg] == cur) begin
					if (stall_cnt[rg] != STALL_MAX)
						stall_cnt[rg] = stall_cnt[rg] + 16'd1;
					if (stall_cnt[rg] < stall_limit || lk)
						halt = 1'b1;
					else
						force_all = 1'b1;
				end
				if (halt) begin
					batch.push_back(make_outcome(KIND_NONE, rg, '0, '0, '0, 1'b0));
				end else begin
					seen_seq[rg]  = cur;
					stall_cnt[rg] = '0;
					while (cnt > 0 && batch.size() < MAX_RESULTS && !halt) begin
						sq = seq_mem[rg][hd];
						if (!force_all && (cur - sq) >= SIGNAL_WINDOW) begin
							halt = 1'b1;
						end else begin
							batch.push_back(make_outcome(KIND_RETIRED, rg, sq,
								flags_mem[rg][hd], cookie_mem[rg][hd], force_all));
							hd  = (hd + 1) % SLOTS;
							cnt = cnt - 1;
						end
					end
					fifo_head[rg] = hd;
					fifo_cnt[rg]  = cnt;
					busy = (cnt > 0);
					if (batch.size() == 0)
						batch.push_back(make_outcome(KIND_NONE, rg, '0, '0, '0, 1'b0));
				end
			end
		end
		foreach (batch[i]) begin
			batch[i].busy = busy;
			batch[i].last = (i == batch.size() - 1);
			awaited_results.push_back(batch[i]);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp,
			input logic [63:0] act);
		if (exp !== act) begin
			$error("%s expected %0h actual %0h", name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_limit = STALL_LIMIT_RESET;
			for (int r = 0; r < RINGS; r++) begin
				next_seq[r]  = 32'd1;
				seen_seq[r]  = '0;
				stall_cnt[r] = '0;
				fifo_head[r] = 0;
				fifo_cnt[r]  = 0;
			end
			awaited_results.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: kind %0d ring %0d", kind, out_ring);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", want.kind, kind);
					check_field("out_ring", want.rg, out_ring);
					check_field("out_seqno", want.seqno, out_seqno);
					check_field("out_flags", want.flags, out_flags);
					check_field("out_cookie", want.cookie, out_cookie);
					check_field("forced", want.forced, forced);
					check_field("ring_busy", want.busy, ring_busy);
					check_field("last", want.last, last);
				end
			end
			if (cfg_we)
				stall_limit = cfg_wdata;
			if (in_valid && !in_stall)
				step_timeline(op_t'(op), ring, fence_flags, cookie, completed_seqno, link_up);
			if (wrap_up && awaited_results.size() != 0) begin
				$error("%0d results never arrived", awaited_results.size());
				fail_count += awaited_results.size();
				awaited_results.delete();
			end
		end
	end

endmodule

@@ verif/fence_timeline_tracker_top_test.sv @@
module fence_timeline_tracker_top_test;

	import ftt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RINGS = RING_COUNT_DEF;

	logic        clk = 1'b0;
	logic        arst_n;

	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [7:0]  ring;
	logic [31:0] fence_flags;
	logic [63:0] cookie;
	logic [31:0] completed_seqno;
	logic        link_up;

	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [7:0]  out_ring;
	logic [31:0] out_seqno;
	logic [31:0] out_flags;
	logic [63:0] out_cookie;
	logic        forced;
	logic        ring_busy;
	logic        last;

	logic        cfg_we;
	logic [15:0] cfg_wdata;

	logic        wrap_up;
	int unsigned fail_count;

	// Pacing switches: when set, that side inserts random gaps between items.
	logic        tx_pace;
	logic        rx_pace;

	// Items accepted by the block, and items whose final result has been taken.
	int          items_sent;
	int          items_done = 0;

	// Rough per-ring view of the timeline, used only to aim completed numbers
	// near the sequence numbers actually waiting in the FIFO.
	logic [31:0] issued   [RINGS];
	logic [31:0] seen_cur [RINGS];

	logic [15:0] phase_limit [5];

	fence_timeline_tracker_top uut (.*);

	fence_timeline_tracker_checker chk (.*);

	always #5 clk = ~clk;

	// Count an item as finished once the result flagged last is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall && last)
			items_done <= items_done + 1;
	end

	// Offer one item, hold it until the block takes it, and keep the ring view
	// current. A zero gap keeps valid high straight into the next item.
	task automatic send_item(input op_t o, input logic [7:0] rg, input logic [31:0] fl,
			input logic [63:0] ck, input logic [31:0] cur, input logic lk);
		int gap;
		gap = tx_pace ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		op              <= o;
		ring            <= rg;
		fence_flags     <= fl;
		cookie          <= ck;
		completed_seqno <= cur;
		link_up         <= lk;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (rg < RINGS) begin
			if (o == OP_SUBMIT)
				issued[rg] = issued[rg] + 32'd1;
			else
				seen_cur[rg] = cur;
		end
	endtask

	// Drop valid and wait for every outstanding result, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (items_done != items_sent) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the stall limit with the block idle.
	task automatic set_limit(input logic [15:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Draw one random item. Most traffic lands on a few rings so FIFOs fill and
	// stall counts build; completed numbers mostly follow the issued numbers.
	task automatic random_item();
		int pick;
		logic [7:0]  rg;
		logic [31:0] cur;
		logic [31:0] span;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			rg = $urandom_range(0, 3);
		else if (pick < 95)
			rg = $urandom_range(4, 15);
		else
			rg = $urandom_range(16, 255);
		if ($urandom_range(0, 99) < 55) begin
			send_item(OP_SUBMIT, rg, $urandom, {$urandom, $urandom}, $urandom,
				$urandom_range(0, 1));
		end else begin
			if (rg >= RINGS) begin
				cur = $urandom;
			end else begin
				span = issued[rg] - seen_cur[rg];
				case ($urandom_range(0, 9))
					0, 1: begin
						cur = seen_cur[rg];
					end
					7: begin
						cur = $urandom;
					end
					8: begin
						cur = issued[rg] + $urandom_range(0, 2);
					end
					9: begin
						cur = issued[rg] + SIGNAL_WINDOW - $urandom_range(0, 2);
					end
					default: begin
						if (span > 40)
							cur = issued[rg] - $urandom_range(0, 3);
						else
							cur = seen_cur[rg] + $urandom_range(0, span);
					end
				endcase
			end
			send_item(OP_POLL, rg, $urandom, {$urandom, $urandom}, cur,
				$urandom_range(0, 2) != 0);
		end
	endtask

	// Result side: hold off a random number of cycles, then take one result.
	initial begin
		int hold;
		out_stall = 1'b1;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = rx_pace ? $urandom_range(0, 13) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		op              = OP_SUBMIT;
		ring            = '0;
		fence_flags     = '0;
		cookie          = '0;
		completed_seqno = '0;
		link_up         = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		wrap_up         = 1'b0;
		tx_pace         = 1'b1;
		rx_pace         = 1'b1;
		items_sent      = 0;
		for (int r = 0; r < RINGS; r++) begin
			issued[r]   = '0;
			seen_cur[r] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, stall limit at its reset value.
		// Two fences on ring 0 with all-ones and all-zero payloads.
		send_item(OP_SUBMIT, 8'd0, '1, '1, '0, 1'b0);
		send_item(OP_SUBMIT, 8'd0, '0, '0, '1, 1'b1);
		// Bad ring on submit and on poll, then a poll of an idle ring.
		send_item(OP_SUBMIT, 8'd255, 32'h1234_5678, 64'h1, '0, 1'b0);
		send_item(OP_POLL, 8'd16, '0, '0, 32'd5, 1'b1);
		send_item(OP_POLL, 8'd5, '0, '0, 32'd7, 1'b1);
		// Stalled poll below the limit with the link down.
		send_item(OP_POLL, 8'd0, '0, '0, 32'd0, 1'b0);
		// Retire seq 1 only; seq 2 lies one past the completed number, so it is not signaled.
		send_item(OP_POLL, 8'd0, '0, '0, 32'd1, 1'b1);
		// Completed 0x8000_0000 still signals seq 2 (distance one below the window).
		send_item(OP_POLL, 8'd0, '0, '0, 32'h8000_0000, 1'b0);
		// Distance exactly at the window: nothing retires, then progress retires.
		send_item(OP_SUBMIT, 8'd1, 32'hA5A5_5A5A, 64'hDEAD_BEEF_0000_FFFF, '0, 1'b0);
		send_item(OP_POLL, 8'd1, '0, '0, 32'h8000_0000, 1'b1);
		send_item(OP_POLL, 8'd1, '0, '0, 32'h8000_0000, 1'b0);
		send_item(OP_POLL, 8'd1, '0, '0, 32'd1, 1'b1);
		// Fill ring 15, overflow it once, then retire the full FIFO in one poll.
		for (int i = 0; i < 17; i++)
			send_item(OP_SUBMIT, 8'd15, i, {$urandom, $urandom}, '0, 1'b0);
		send_item(OP_POLL, 8'd15, '0, '0, 32'd16, 1'b1);

		// Limit zero: the first stalled poll with the link down forces.
		set_limit(16'd0);
		send_item(OP_SUBMIT, 8'd2, $urandom, {$urandom, $urandom}, '0, 1'b0);
		send_item(OP_POLL, 8'd2, '0, '0, 32'd0, 1'b0);

		// Saturate the stall count at the top limit, back to back.
		set_limit(STALL_MAX);
		tx_pace = 1'b0;
		rx_pace = 1'b0;
		send_item(OP_SUBMIT, 8'd3, $urandom, {$urandom, $urandom}, '0, 1'b0);
		repeat (65533)
			send_item(OP_POLL, 8'd3, $urandom, {$urandom, $urandom}, 32'd0, 1'b1);
		// One short of the limit: link down must not force yet.
		send_item(OP_POLL, 8'd3, '0, '0, 32'd0, 1'b0);
		repeat (64)
			send_item(OP_POLL, 8'd3, $urandom, {$urandom, $urandom}, 32'd0, 1'b1);
		// Saturated count sits at the limit, so this one forces.
		send_item(OP_POLL, 8'd3, '0, '0, 32'd0, 1'b0);

		// Random phases, each under its own stall limit.
		phase_limit[0] = 16'd1;
		phase_limit[1] = $urandom_range(2, 6);
		phase_limit[2] = STALL_MAX;
		phase_limit[3] = $urandom_range(1, 65535);
		phase_limit[4] = 16'd2;
		for (int p = 0; p < 5; p++) begin
			set_limit(phase_limit[p]);
			for (int i = 0; i < 92; i++) begin
				// Redraw pacing now and then so gapless stretches appear too.
				if (i % 23 == 0) begin
					tx_pace = $urandom_range(0, 2) != 0;
					rx_pace = $urandom_range(0, 2) != 0;
				end
				// Hold off mid-phase until every result is back.
				if (i == 46)
					drain();
				random_item();
			end
		end

		drain();
		wrap_up <= 1'b1;
		@(posedge clk);
		wrap_up <= 1'b0;
		@(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
